/* sv/cmdl_pkg.sv */
package cmdl_pkg;

  localparam int DEF_LINE_LEN    = 32;
  localparam int DEF_NUM_ENTRIES = 16;
  localparam int QUEUE_DEPTH     = 2;

  localparam int OP_W       = 2;
  localparam int BYTE_W     = 8;
  localparam int ENTRY_IN_W = 4;
  localparam int POS_IN_W   = 5;
  localparam int CMD_W      = 4;
  localparam int TICK_W     = 32;

  localparam logic [BYTE_W-1:0] CHAR_CR       = 8'h0D;
  localparam logic [BYTE_W-1:0] CHAR_LF       = 8'h0A;
  localparam logic [TICK_W-1:0] RESET_TIMEOUT = 32'd1000000;

  typedef enum logic [OP_W-1:0] {
    OP_BYTE = 2'd0,
    OP_TICK = 2'd1,
    OP_CHAR = 2'd2,
    OP_LEN  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    Q_MATCH   = 2'd0,
    Q_INVALID = 2'd1,
    Q_CHAR    = 2'd2,
    Q_LEN     = 2'd3
  } qop_t;

  function automatic int entry_w(int num_entries);
    return (num_entries > 1) ? $clog2(num_entries) : 1;
  endfunction

  // opcode, line snapshot, count, entry, position, byte, clipped length
  function automatic int q_width(int line_len, int num_entries);
    return 2 + line_len * BYTE_W + $clog2(line_len) + entry_w(num_entries)
           + $clog2(line_len) + BYTE_W + $clog2(line_len + 1);
  endfunction

endpackage

/* sv/cmdl_fifo.sv */
module cmdl_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full      = (fill == CNT_W'(DEPTH));
  assign not_empty = (fill != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

endmodule

/* sv/cmdl_front.sv */
module cmdl_front #(
  parameter int LINE_LEN    = 32,
  parameter int NUM_ENTRIES = 16,
  parameter int Q_W         = 300
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cmdl_pkg::OP_W-1:0]       opcode,
  input  logic [cmdl_pkg::BYTE_W-1:0]     data_byte,
  input  logic [cmdl_pkg::ENTRY_IN_W-1:0] entry,
  input  logic [cmdl_pkg::POS_IN_W-1:0]   position,
  input  logic                            cfg_we,
  input  logic [cmdl_pkg::TICK_W-1:0]     cfg_wdata,
  input  logic                            back_busy,
  input  logic                            q_full,
  output logic                            q_push,
  output logic [Q_W-1:0]                  q_data
);

  import cmdl_pkg::*;

  localparam int CNT_W   = $clog2(LINE_LEN);
  localparam int ENTRY_W = entry_w(NUM_ENTRIES);
  localparam int POS_W   = $clog2(LINE_LEN);
  localparam int LEN_W   = $clog2(LINE_LEN + 1);

  logic [LINE_LEN-1:0][BYTE_W-1:0] line_buf;
  logic [CNT_W-1:0]                line_count;
  logic [CNT_W-1:0]                line_count_next;
  logic [TICK_W-1:0]               idle_elapsed;
  logic [TICK_W-1:0]               idle_elapsed_next;
  logic [TICK_W-1:0]               timeout_ticks;
  logic [TICK_W-1:0]               tick_inc;
  logic                            accept;
  logic                            is_term;
  logic                            entry_ok;
  logic                            pos_ok;
  logic                            wr_buf;
  op_t                             op;
  qop_t                            q_op;
  logic [LEN_W-1:0]                q_len;

  assign in_ready = !back_busy && !q_full;
  assign accept   = in_valid && in_ready;
  assign op       = op_t'(opcode);
  assign is_term  = (data_byte == CHAR_CR) || (data_byte == CHAR_LF);
  assign entry_ok = int'(entry) < NUM_ENTRIES;
  assign pos_ok   = int'(position) < LINE_LEN;
  assign tick_inc = (idle_elapsed == '1) ? idle_elapsed : idle_elapsed + 1'b1;
  assign q_len    = (data_byte > BYTE_W'(LINE_LEN - 1)) ? LEN_W'(LINE_LEN)
                                                         : LEN_W'(data_byte);
  assign q_data   = {q_op, line_buf, line_count, ENTRY_W'(entry), POS_W'(position),
                     data_byte, q_len};

  always_comb begin
    line_count_next   = line_count;
    idle_elapsed_next = idle_elapsed;
    q_push            = 1'b0;
    q_op              = Q_INVALID;
    wr_buf            = 1'b0;
    if (accept) begin
      unique case (op)
        OP_BYTE: begin
          if (is_term) begin
            if (line_count != '0) begin
              q_push            = 1'b1;
              q_op              = Q_MATCH;
              line_count_next   = '0;
              idle_elapsed_next = '0;
            end
          end else begin
            idle_elapsed_next = '0;
            if (line_count < CNT_W'(LINE_LEN - 1)) begin
              wr_buf          = 1'b1;
              line_count_next = line_count + 1'b1;
            end else begin
              line_count_next = '0;
              q_push          = 1'b1;
              q_op            = Q_INVALID;
            end
          end
        end
        OP_TICK: begin
          if (line_count != '0) begin
            if (tick_inc >= timeout_ticks) begin
              line_count_next   = '0;
              idle_elapsed_next = '0;
              q_push            = 1'b1;
              q_op              = Q_INVALID;
            end else begin
              idle_elapsed_next = tick_inc;
            end
          end
        end
        OP_CHAR: begin
          if (entry_ok && pos_ok) begin
            q_push = 1'b1;
            q_op   = Q_CHAR;
          end
        end
        OP_LEN: begin
          if (entry_ok) begin
            q_push = 1'b1;
            q_op   = Q_LEN;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count    <= '0;
      idle_elapsed  <= '0;
      timeout_ticks <= RESET_TIMEOUT;
    end else begin
      line_count   <= line_count_next;
      idle_elapsed <= idle_elapsed_next;
      if (cfg_we) begin
        timeout_ticks <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_buf) begin
      line_buf[line_count] <= data_byte;
    end
  end

endmodule

/* sv/cmdl_back.sv */
module cmdl_back #(
  parameter int LINE_LEN    = 32,
  parameter int NUM_ENTRIES = 16,
  parameter int Q_W         = 300
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       q_valid,
  input  logic [Q_W-1:0]             q_data,
  output logic                       q_pop,
  output logic                       busy,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic                       result_kind,
  output logic [cmdl_pkg::CMD_W-1:0] command_number
);

  import cmdl_pkg::*;

  localparam int CNT_W   = $clog2(LINE_LEN);
  localparam int ENTRY_W = entry_w(NUM_ENTRIES);
  localparam int POS_W   = $clog2(LINE_LEN);
  localparam int LEN_W   = $clog2(LINE_LEN + 1);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_SCAN  = 3'b100
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [ENTRY_W-1:0]              scan_idx;
  logic [ENTRY_W-1:0]              scan_idx_next;
  logic [ENTRY_W-1:0]              clr_idx;
  logic [LINE_LEN-1:0][BYTE_W-1:0] chars [NUM_ENTRIES];
  logic [LINE_LEN-1:0][BYTE_W-1:0] rd_row;
  logic [LEN_W-1:0]                lengths [NUM_ENTRIES];

  logic [1:0]                      h_op_raw;
  qop_t                            h_op;
  logic [LINE_LEN-1:0][BYTE_W-1:0] h_line;
  logic [CNT_W-1:0]                h_cnt;
  logic [ENTRY_W-1:0]              h_ent;
  logic [POS_W-1:0]                h_pos;
  logic [BYTE_W-1:0]               h_byte;
  logic [LEN_W-1:0]                h_len;

  logic [LINE_LEN-1:0]             lane_ok;
  logic                            hit;
  logic                            wr_char;
  logic                            wr_len;
  logic                            set_out;
  logic                            set_kind;
  logic [CMD_W-1:0]                set_num;

  assign {h_op_raw, h_line, h_cnt, h_ent, h_pos, h_byte, h_len} = q_data;
  assign h_op = qop_t'(h_op_raw);
  assign busy = (state == ST_CLEAR);

  always_comb begin
    for (int i = 0; i < LINE_LEN; i++) begin
      lane_ok[i] = (CNT_W'(i) >= h_cnt) || (rd_row[i] == h_line[i]);
    end
    hit = (&lane_ok) && (lengths[scan_idx] == LEN_W'(h_cnt));
  end

  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    q_pop         = 1'b0;
    wr_char       = 1'b0;
    wr_len        = 1'b0;
    set_out       = 1'b0;
    set_kind      = 1'b1;
    set_num       = '0;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == ENTRY_W'(NUM_ENTRIES - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid) begin
          unique case (h_op)
            Q_CHAR: begin
              wr_char = 1'b1;
              q_pop   = 1'b1;
            end
            Q_LEN: begin
              wr_len = 1'b1;
              q_pop  = 1'b1;
            end
            Q_INVALID: begin
              if (!out_valid) begin
                set_out = 1'b1;
                q_pop   = 1'b1;
              end
            end
            Q_MATCH: begin
              if (!out_valid) begin
                scan_idx_next = '0;
                state_next    = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (hit) begin
          set_out    = 1'b1;
          set_kind   = 1'b0;
          set_num    = CMD_W'(scan_idx);
          q_pop      = 1'b1;
          state_next = ST_IDLE;
        end else if (scan_idx == ENTRY_W'(NUM_ENTRIES - 1)) begin
          set_out    = 1'b1;
          q_pop      = 1'b1;
          state_next = ST_IDLE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      scan_idx  <= '0;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      for (int e = 0; e < NUM_ENTRIES; e++) begin
        lengths[e] <= '0;
      end
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      if (set_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (wr_len) begin
        lengths[h_ent] <= h_len;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (set_out) begin
      result_kind    <= set_kind;
      command_number <= set_num;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      chars[clr_idx] <= '0;
    end else if (wr_char) begin
      chars[h_ent][h_pos] <= h_byte;
    end
    rd_row <= chars[scan_idx_next];
  end

endmodule

/* sv/command_line_matcher.sv */
// ASCII command-line matcher. Each input word is a received byte, a microsecond
// tick, or a write of one command-table character or length; the one register,
// timeout_ticks, is written through cfg_we/cfg_wdata. Bytes, ticks and table
// writes are taken one per cycle by the front end while the queue is not full
// and the back end is not clearing its table. A CR or LF that ends a non-empty
// line hands a snapshot of the line to a two-word queue; the back end then
// compares it against one table row per cycle, as the character table has a
// single read port. At most one result word follows each input word:
// result_kind 0 with the first matching entry, or 1 for no match, buffer
// overflow or idle timeout. After reset the character table is cleared one row
// per cycle, and in_ready stays low until the clearing is done.
module command_line_matcher #(
  parameter int LINE_LEN    = cmdl_pkg::DEF_LINE_LEN,
  parameter int NUM_ENTRIES = cmdl_pkg::DEF_NUM_ENTRIES
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [cmdl_pkg::OP_W-1:0]       opcode,
  input  logic [cmdl_pkg::BYTE_W-1:0]     data_byte,
  input  logic [cmdl_pkg::ENTRY_IN_W-1:0] entry,
  input  logic [cmdl_pkg::POS_IN_W-1:0]   position,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            result_kind,
  output logic [cmdl_pkg::CMD_W-1:0]      command_number,
  input  logic                            cfg_we,
  input  logic [cmdl_pkg::TICK_W-1:0]     cfg_wdata
);

  import cmdl_pkg::*;

  localparam int Q_W = q_width(LINE_LEN, NUM_ENTRIES);

  logic           back_busy;
  logic           q_full;
  logic           q_push;
  logic [Q_W-1:0] q_push_data;
  logic           q_pop;
  logic [Q_W-1:0] q_pop_data;
  logic           q_valid;

  cmdl_front #(
    .LINE_LEN    (LINE_LEN),
    .NUM_ENTRIES (NUM_ENTRIES),
    .Q_W         (Q_W)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .opcode    (opcode),
    .data_byte (data_byte),
    .entry     (entry),
    .position  (position),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .back_busy (back_busy),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_push_data)
  );

  cmdl_fifo #(
    .WIDTH (Q_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_valid)
  );

  cmdl_back #(
    .LINE_LEN    (LINE_LEN),
    .NUM_ENTRIES (NUM_ENTRIES),
    .Q_W         (Q_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (q_valid),
    .q_data         (q_pop_data),
    .q_pop          (q_pop),
    .busy           (back_busy),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .result_kind    (result_kind),
    .command_number (command_number)
  );

endmodule
